// File: rtl/core/ualt_pkg.sv
// Shared definitions for the unsorted array list table.
// Holds operation and status codes, the sequencer state type and the cell
// control struct; no dependencies.
package ualt_pkg;

  // Default number of entries held by the list.
  localparam int DEF_CAPACITY = 128;

  // Field widths fixed by the interface.
  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int POS_W = 7;
  localparam int FC_W  = 8;

  // Hit bits examined per scan cycle.
  localparam int GROUP_W = 3;
  localparam int GROUP   = 1 << GROUP_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } ualt_state_t;

  // Strobes broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // register the compare result of each cell
    logic ins;  // the cell at the fill position loads the key
    logic rem;  // cells at or above the removal index take their neighbor's key
  } ualt_ctrl_t;

endpackage

// File: rtl/core/ualt_cell.sv
// One storage cell of the list chain: a key register and a registered hit flag.
// Depends on ualt_pkg.
module ualt_cell #(
  parameter int CAPACITY = ualt_pkg::DEF_CAPACITY,
  parameter int INDEX    = 0,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk,
  input  ualt_pkg::ualt_ctrl_t        ctrl,
  input  logic [ualt_pkg::KEY_W-1:0]  cmp_key,
  input  logic [CW-1:0]               count,
  input  logic [IW-1:0]               idx,
  input  logic [ualt_pkg::KEY_W-1:0]  next_key,
  output logic [ualt_pkg::KEY_W-1:0]  key_o,
  output logic                        hit_o
);
  import ualt_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             hit_r;
  logic             held;
  logic             load;
  logic             shift;

  // The cell holds a live entry when its place lies below the fill count.
  assign held  = count > CW'(INDEX);
  assign load  = ctrl.ins && (count == CW'(INDEX));
  assign shift = ctrl.rem && (idx <= IW'(INDEX));

  // Key storage: append load or move down from the upper neighbor.
  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= cmp_key;
    end else if (shift) begin
      key_r <= next_key;
    end
  end

  // Local compare, registered for the scan.
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      hit_r <= held && (key_r == cmp_key);
    end
  end

  assign key_o = key_r;
  assign hit_o = hit_r;

endmodule

// File: rtl/core/ualt_chain.sv
// Row of list cells, each handing its key to the cell below on a removal.
// Depends on ualt_pkg and ualt_cell.
module ualt_chain #(
  parameter int CAPACITY = ualt_pkg::DEF_CAPACITY,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk,
  input  ualt_pkg::ualt_ctrl_t        ctrl,
  input  logic [ualt_pkg::KEY_W-1:0]  cmp_key,
  input  logic [CW-1:0]               count,
  input  logic [IW-1:0]               idx,
  output logic [CAPACITY-1:0]         hit
);
  import ualt_pkg::*;

  logic [KEY_W-1:0] keys [CAPACITY];

  // Each cell takes its upper neighbor's key; the top cell keeps its own,
  // which lies beyond the fill count after a removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] upper;
    if (i == CAPACITY - 1) begin : g_top
      assign upper = keys[i];
    end else begin : g_mid
      assign upper = keys[i+1];
    end

    ualt_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i),
      .CW       (CW),
      .IW       (IW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cmp_key  (cmp_key),
      .count    (count),
      .idx      (idx),
      .next_key (upper),
      .key_o    (keys[i]),
      .hit_o    (hit[i])
    );
  end

endmodule

// File: rtl/core/unsorted_array_list_table.sv
// Top level of the unsorted array list table: sequencer, scan and result register.
// Depends on ualt_pkg, ualt_chain and ualt_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_ready, in_operation, in_key | into block
//  result  | out_valid, out_ready, out_status,       | out of block
//          | out_position, out_fill_count            |
//
// Insert and the unused code go from the compare state straight to the done state,
// where the result loads; search adds the scan state, and remove adds the scan state
// and, on a match, the shift state. The first-match scan walks the registered hit bits
// 8 cells per cycle, and the removal shift moves the whole cell chain at once; the next
// input transfer can follow in the cycle after the load.
// Reset clears the fill count, sequencer and result valid; cell contents are
// left as they are. A stalled result holds in the output register while the
// next item is taken; that item then waits in its final state for the slot.
module unsorted_array_list_table #(
  parameter int CAPACITY = ualt_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ualt_pkg::OP_W-1:0]     in_operation,
  input  logic signed [ualt_pkg::KEY_W-1:0] in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ualt_pkg::ST_W-1:0]     out_status,
  output logic [ualt_pkg::POS_W-1:0]    out_position,
  output logic [ualt_pkg::FC_W-1:0]     out_fill_count
);
  import ualt_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  ualt_state_t state_r, state_nxt;

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    count_r;
  logic [IW-1:0]    idx_r;
  logic [GW-1:0]    grp_r;
  logic [ST_W-1:0]  res_status_r;
  logic [POS_W-1:0] res_pos_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [POS_W-1:0] out_pos_r;
  logic [FC_W-1:0]  out_fc_r;

  ualt_ctrl_t          ctrl;
  logic [CAPACITY-1:0] hit;
  logic [NGRP*GROUP-1:0] hit_pad;
  logic [GROUP-1:0]    slice;
  logic                slice_hit;
  logic [GROUP_W-1:0]  slice_pos;
  logic                last_grp;
  logic                has_room;
  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                scan_en;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign has_room = count_r < CW'(CAPACITY);
  assign last_grp = grp_r == GW'(NGRP - 1);

  // Cell chain holding the list.
  ualt_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .IW       (IW)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .cmp_key (key_r),
    .count   (count_r),
    .idx     (idx_r),
    .hit     (hit)
  );

  // First hit within the current group of eight hit bits.
  assign hit_pad = (NGRP * GROUP)'(hit);
  assign slice   = hit_pad[{grp_r, {GROUP_W{1'b0}}} +: GROUP];

  always_comb begin
    slice_hit = 1'b0;
    slice_pos = '0;
    for (int j = GROUP - 1; j >= 0; j--) begin
      if (slice[j]) begin
        slice_hit = 1'b1;
        slice_pos = GROUP_W'(j);
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (op_r == OP_SEARCH || op_r == OP_REMOVE) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (slice_hit && op_r == OP_REMOVE) begin
          state_nxt = S_SHIFT;
        end else if (slice_hit || last_grp) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control strobes per state.
  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    scan_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_CMP: begin
        ctrl.cmp = 1'b1;
        ctrl.ins = (op_r == OP_INSERT) && has_room;
      end
      S_SCAN:  scan_en  = 1'b1;
      S_SHIFT: ctrl.rem = 1'b1;
      S_DONE:  out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.ins) begin
        count_r <= count_r + CW'(1);
      end else if (ctrl.rem) begin
        count_r <= count_r - CW'(1);
      end
      if (ctrl.cmp) begin
        grp_r <= '0;
      end else if (scan_en && !slice_hit && !last_grp) begin
        grp_r <= grp_r + GW'(1);
      end
    end
  end

  // Item capture and result formation.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    if (ctrl.cmp) begin
      res_status_r <= ST_DONE;
      res_pos_r    <= '0;
      if (op_r == OP_INSERT) begin
        if (has_room) begin
          res_pos_r <= POS_W'(count_r);
        end else begin
          res_status_r <= ST_FULL;
        end
      end
    end
    if (scan_en) begin
      if (slice_hit) begin
        idx_r     <= IW'({grp_r, slice_pos});
        res_pos_r <= POS_W'({grp_r, slice_pos});
      end else if (last_grp) begin
        res_status_r <= ST_MISSING;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_fc_r     <= FC_W'(count_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_position   = out_pos_r;
  assign out_fill_count = out_fc_r;

`ifndef SYNTHESIS
  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // A removal shift drops the fill count by exactly one.
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("removal did not decrement the fill count");

  // A full status is only formed when the list is at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r == ST_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("full status with room left");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the unsorted array list table.
// Drives insert, search and remove transfers and checks every result against an
// in-bench model of the list; depends on ualt_pkg and unsorted_array_list_table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ualt_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int MAX_IDLE   = 18;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_WAIT  = 40;
  localparam int SEG_ITEMS  = 100;
  localparam int SEG_COUNT  = 15;

  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX   = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_ONES  = 32'hffff_ffff;

  // One result as the block reports it.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [FC_W-1:0]  fill_count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_operation = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic [POS_W-1:0]        out_position;
  logic [FC_W-1:0]         out_fill_count;

  // Shadow copy of the list contents and its fill count.
  logic [KEY_W-1:0] shadow_keys [CAP];
  int unsigned      shadow_count = 0;

  // Results predicted at input transfer, oldest first.
  list_result_t pending_results [$];

  int  error_count   = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  done_count    = 0;
  int  missing_count = 0;
  int  full_count    = 0;
  int  quiet_cycles  = 0;
  int  stall_left    = 0;
  bit  tx_idle_on    = 1'b1;
  bit  rx_stall_on   = 1'b1;

  unsorted_array_list_table uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_position   (out_position),
    .out_fill_count (out_fill_count)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    list_result_t res;
    int hit_idx;
    res.status   = ST_DONE;
    res.position = '0;
    hit_idx      = -1;
    // First match wins, so duplicates resolve to the lowest index.
    for (int i = 0; i < shadow_count; i++) begin
      if (hit_idx < 0 && shadow_keys[i] == key) hit_idx = i;
    end
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          res.position = shadow_count[POS_W-1:0];
          shadow_count++;
        end
      end
      OP_SEARCH: begin
        if (hit_idx >= 0) res.position = hit_idx[POS_W-1:0];
        else res.status = ST_MISSING;
      end
      OP_REMOVE: begin
        if (hit_idx >= 0) begin
          for (int k = hit_idx; k + 1 < shadow_count; k++) shadow_keys[k] = shadow_keys[k + 1];
          shadow_count--;
          res.position = hit_idx[POS_W-1:0];
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: ;
    endcase
    res.fill_count = shadow_count[FC_W-1:0];
    return res;
  endfunction

  // Key choice that favors hits and duplicates but still covers every key bit.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && shadow_count > 0) return shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (r < 65) return KEY_W'($signed($urandom_range(0, 7)) - 2);
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return KEY_ONES;
      default: return '0;
    endcase
  endfunction

  // Send one item: optional idle gap, then hold valid until the transfer.
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    int gap;
    list_result_t res;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    do @(posedge clk); while (!in_ready);
    res = apply_list_op(op, key);
    pending_results.push_back(res);
    sent_count++;
    case (res.status)
      ST_DONE:    done_count++;
      ST_MISSING: missing_count++;
      default:    full_count++;
    endcase
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extreme keys, every operation, empty-list misses, duplicates and the unused code.
  task automatic test_directed();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    send_item(OP_SEARCH, '0);
    send_item(OP_REMOVE, KEY_ONES);
    send_item(OP_UNUSED, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_ONES);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, KEY_ONES);
    send_item(OP_SEARCH, KEY_MIN);
    send_item(OP_SEARCH, KEY_MAX);
    send_item(OP_SEARCH, 32'd5);
    send_item(OP_SEARCH, '0);
    send_item(OP_SEARCH, 32'h7fff_fffe);
    send_item(OP_UNUSED, KEY_MIN);
    send_item(OP_REMOVE, 32'd5);
    send_item(OP_SEARCH, 32'd5);
    send_item(OP_REMOVE, KEY_MIN);
    send_item(OP_REMOVE, KEY_ONES);
    send_item(OP_REMOVE, KEY_ONES);
    send_item(OP_SEARCH, KEY_ONES);
    send_item(OP_REMOVE, KEY_MAX);
    send_item(OP_REMOVE, 32'd5);
    send_item(OP_REMOVE, 32'd5);
    send_item(OP_SEARCH, KEY_MAX);
    drain_results();
  endtask

  // Fill the list to capacity, hit the full case and remove at both ends.
  task automatic test_full_list();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    while (shadow_count < CAP) send_item(OP_INSERT, $urandom);
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    repeat (3) send_item(OP_INSERT, $urandom);
    send_item(OP_UNUSED, $urandom);
    send_item(OP_SEARCH, shadow_keys[CAP - 1]);
    send_item(OP_SEARCH, shadow_keys[0]);
    send_item(OP_REMOVE, shadow_keys[CAP - 1]);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_REMOVE, shadow_keys[0]);
    send_item(OP_SEARCH, KEY_MIN);
    drain_results();
  endtask

  // Random operations steered toward a fill target that changes per segment.
  task automatic test_random_mix();
    int target;
    int r;
    logic [OP_W-1:0] op;
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg % 3)
        0: target = CAP;
        1: target = 0;
        default: target = $urandom_range(0, CAP);
      endcase
      // Idle patterns rotate so some segments run back to back on both sides.
      tx_idle_on  = (seg % 4 == 0) || (seg % 4 == 2);
      rx_stall_on = (seg % 4 == 0) || (seg % 4 == 3);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) op = OP_UNUSED;
        else if (shadow_count < target) op = (r < 62) ? OP_INSERT : (r < 82) ? OP_SEARCH : OP_REMOVE;
        else op = (r < 17) ? OP_INSERT : (r < 47) ? OP_SEARCH : OP_REMOVE;
        send_item(op, pick_key());
      end
      if (seg == SEG_COUNT / 2) drain_results();
    end
  endtask

  // Result side: random back-pressure and the field-by-field check.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no expectation: status %0d position %0d fill %0d",
                 $time, out_status, out_position, out_fill_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   out_status);
        end
        if (out_position !== want.position) begin
          error_count++;
          $display("%0t: position mismatch: expected %0d actual %0d", $time, want.position,
                   out_position);
        end
        if (out_fill_count !== want.fill_count) begin
          error_count++;
          $display("%0t: fill count mismatch: expected %0d actual %0d", $time,
                   want.fill_count, out_fill_count);
        end
      end
      if (rx_stall_on && $urandom_range(0, MAX_IDLE) > 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, MAX_IDLE);
      end
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_random_mix();
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Covered %0d operations, %0d results checked: %0d done or found, %0d missing, %0d full.",
             sent_count, checked_count, done_count, missing_count, full_count);
    $display("Included empty and full lists, duplicate keys, extreme keys and the unused code.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
